[src/sqlagg_pkg.sv]
// shared types and constants of the sql aggregate accumulator
package sqlagg_pkg;

  // fixed field widths of the stream payload
  localparam int VALUE_BITS  = 32;
  localparam int RESULT_BITS = 64;
  localparam int MODE_BITS   = 3;

  // aggregate modes; codes above average act as sum
  localparam logic [MODE_BITS-1:0] MODE_SUM    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_MIN    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_MAX    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_CHOOSE = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_AVG    = 3'd4;

  // input kind codes
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_FIN = 1'b1;

  // operation carried from front to back
  typedef enum logic {
    OP_ADD,
    OP_FIN
  } op_t;

  // one queued operation
  typedef struct packed {
    op_t                    op;
    logic [MODE_BITS-1:0]   mode;
    logic [VALUE_BITS-1:0]  value;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

[src/sqlagg_queue.sv]
// short first-word-fall-through queue between front and back
module sqlagg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full  = (fill == CW'(DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[src/sqlagg_front.sv]
// input side: mode register, null filtering and value sign extension
module sqlagg_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sqlagg_pkg::MODE_BITS-1:0]    cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sqlagg_pkg::VALUE_BITS-1:0]   s_tdata,
  input  logic [1:0]                          s_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output sqlagg_pkg::entry_t                  q_entry
);

  logic [sqlagg_pkg::MODE_BITS-1:0] agg_mode;
  logic                             kind;
  logic                             is_null;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      agg_mode <= sqlagg_pkg::MODE_SUM;
    end else if (cfg_we) begin
      agg_mode <= cfg_wdata;
    end
  end

  assign kind     = s_tuser[0];
  assign is_null  = s_tuser[1];
  assign s_tready = !q_full;

  // null adds are dropped here, everything else goes to the queue
  assign q_push = s_tvalid && s_tready && !(kind == sqlagg_pkg::KIND_ADD && is_null);

  // classify and tag with the mode in force
  always_comb begin
    q_entry.op    = (kind == sqlagg_pkg::KIND_FIN) ? sqlagg_pkg::OP_FIN : sqlagg_pkg::OP_ADD;
    q_entry.mode  = agg_mode;
    q_entry.value = sqlagg_pkg::VALUE_BITS'($signed(s_tdata[VALUE_WIDTH-1:0]));
  end

endmodule

[src/sqlagg_back.sv]
// execution side: accumulator, count, average divider and result register
module sqlagg_back #(
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  sqlagg_pkg::entry_t                   q_head,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sqlagg_pkg::RESULT_BITS-1:0]   m_tdata,
  output logic                                 m_tuser
);

  localparam int RW = sqlagg_pkg::RESULT_BITS;
  localparam int DW = RW + FRAC_BITS;
  localparam int SW = $clog2(DW + 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                  state;
  logic [RW-1:0]           acc;
  logic [COUNT_WIDTH-1:0]  cnt;
  logic                    seen;
  logic [DW-1:0]           dvd;
  logic [COUNT_WIDTH-1:0]  rem;
  logic [COUNT_WIDTH-1:0]  divisor;
  logic                    neg;
  logic [SW-1:0]           step;
  logic [RW-1:0]           out_value;
  logic                    out_null;
  logic                    out_valid;

  logic                    out_free;
  logic                    out_load;
  logic [RW-1:0]           vx;
  logic [RW-1:0]           acc_next;
  logic [RW-1:0]           mag;
  logic [COUNT_WIDTH+1:0]  diff;
  logic [DW-1:0]           limit;
  logic [RW-1:0]           sat_res;
  logic [RW-1:0]           avg_res;

  assign out_free = !out_valid || m_tready;
  assign q_pop    = q_valid && (state == ST_RUN)
                    && (q_head.op == sqlagg_pkg::OP_ADD || out_free);

  // a result enters the output register
  assign out_load = (q_pop && q_head.op == sqlagg_pkg::OP_FIN
                     && !(seen && q_head.mode == sqlagg_pkg::MODE_AVG))
                    || (state == ST_DONE && out_free);

  assign vx  = RW'($signed(q_head.value));
  assign mag = acc[RW-1] ? (~acc + 1'b1) : acc;

  // fold one value under the tagged mode
  always_comb begin
    acc_next = acc;
    unique case (q_head.mode)
      sqlagg_pkg::MODE_MIN: begin
        if (!seen || $signed(vx) < $signed(acc)) acc_next = vx;
      end
      sqlagg_pkg::MODE_MAX: begin
        if (!seen || $signed(acc) < $signed(vx)) acc_next = vx;
      end
      sqlagg_pkg::MODE_CHOOSE: begin
        if (!seen) acc_next = vx;
      end
      default: begin
        acc_next = acc + vx;
      end
    endcase
  end

  // one restoring division step
  assign diff = {1'b0, rem, dvd[DW-1]} - {2'b00, divisor};

  // saturate the fixed-point quotient and restore its sign
  assign limit   = neg ? DW'({1'b1, {(RW-1){1'b0}}}) : DW'({1'b0, {(RW-1){1'b1}}});
  assign sat_res = (dvd > limit) ? limit[RW-1:0] : dvd[RW-1:0];
  assign avg_res = neg ? (~sat_res + 1'b1) : sat_res;

  // sequencer, aggregate state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      acc       <= '0;
      cnt       <= '0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !m_tready);
      unique case (state)
        ST_RUN: begin
          if (q_pop) begin
            if (q_head.op == sqlagg_pkg::OP_ADD) begin
              acc  <= acc_next;
              seen <= 1'b1;
              if (cnt != {COUNT_WIDTH{1'b1}}) cnt <= cnt + 1'b1;
            end else begin
              if (seen && q_head.mode == sqlagg_pkg::MODE_AVG) begin
                neg     <= acc[RW-1];
                dvd     <= DW'(mag) << FRAC_BITS;
                rem     <= '0;
                divisor <= cnt;
                step    <= SW'(DW);
                state   <= ST_DIV;
              end else begin
                out_value <= seen ? acc : '0;
                out_null  <= !seen;
              end
              acc  <= '0;
              cnt  <= '0;
              seen <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (!diff[COUNT_WIDTH+1]) begin
            rem <= diff[COUNT_WIDTH-1:0];
            dvd <= {dvd[DW-2:0], 1'b1};
          end else begin
            rem <= {rem[COUNT_WIDTH-2:0], dvd[DW-1]};
            dvd <= {dvd[DW-2:0], 1'b0};
          end
          step <= step - 1'b1;
          if (step == SW'(1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_value <= avg_res;
            out_null  <= 1'b0;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_null;

endmodule

[src/sql_aggregate_accumulator.sv]
// sql aggregate accumulator: sum, min, max, choose and average with null skipping
// latency: an item is registered in the queue before it reaches the back end; a sum, min, max or
//   choose result is then registered in the output register, an average after the restoring division
// throughput: one add per cycle while the queue has room; an average finalize holds the back end
//   while the one-bit-per-cycle restoring divider runs and until its result enters the output register
// reset: rst synchronous, clears mode to sum, aggregate state, queue and result valid
module sql_aggregate_accumulator #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sqlagg_pkg::MODE_BITS-1:0]    cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sqlagg_pkg::VALUE_BITS-1:0]   s_tdata,   // value
  input  logic [1:0]                          s_tuser,   // kind, is_null
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sqlagg_pkg::RESULT_BITS-1:0]  m_tdata,   // result_value
  output logic                                m_tuser    // result_null
);

  logic                                q_full;
  logic                                q_push;
  logic                                q_pop;
  logic                                q_valid;
  sqlagg_pkg::entry_t                  q_entry;
  logic [sqlagg_pkg::ENTRY_BITS-1:0]   q_head_bits;
  sqlagg_pkg::entry_t                  q_head;

  // front end
  sqlagg_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // decoupling queue
  sqlagg_queue #(
    .WIDTH (sqlagg_pkg::ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head_bits)
  );

  assign q_head = sqlagg_pkg::entry_t'(q_head_bits);

  // back end
  sqlagg_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // a null result always carries a zero value
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("null result with nonzero value");

  // the queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  // the back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  // no result is pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

[test/sql_aggregate_accumulator_tb.sv]
// testbench for the sql aggregate accumulator: directed table, random groups, predictor
`timescale 1ns / 1ps

module sql_aggregate_accumulator_tb;

  localparam int FRAC        = 16;
  localparam int DRAIN       = 100;   // longer than an average finalize in the back end
  localparam int HOLD_CYCLES = 300;
  localparam logic [sqlagg_pkg::MODE_BITS-1:0] MODE_SPARE = 3'd7;

  // one aggregate result as it leaves the block
  typedef struct packed {
    logic [sqlagg_pkg::RESULT_BITS-1:0] value;
    logic                               is_null;
  } agg_result_t;

  // one row of the directed table
  typedef struct {
    logic [sqlagg_pkg::MODE_BITS-1:0]   mode;
    logic                               kind;
    logic [sqlagg_pkg::VALUE_BITS-1:0]  value;
    logic                               is_null;
    bit                                 typed;
    logic [sqlagg_pkg::RESULT_BITS-1:0] want_value;
    logic                               want_null;
  } dir_row_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_we;
  logic [sqlagg_pkg::MODE_BITS-1:0]   cfg_wdata;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [sqlagg_pkg::VALUE_BITS-1:0]  s_tdata;    // value
  logic [1:0]                         s_tuser;    // kind, is_null
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [sqlagg_pkg::RESULT_BITS-1:0] m_tdata;    // result_value
  logic                               m_tuser;    // result_null

  // predictor state
  logic [sqlagg_pkg::MODE_BITS-1:0]   model_mode;
  logic signed [63:0]                 model_acc;
  logic [31:0]                        model_cnt;
  logic                               model_seen;

  agg_result_t pending_results[$];
  dir_row_t    dir_tab[$];
  int          errors = 0;
  bit          quiet_tx = 0;
  bit          quiet_rx = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;

  sql_aggregate_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fold one add item into the predicted state
  function automatic void fold_value(input logic [sqlagg_pkg::VALUE_BITS-1:0] raw,
                                     input logic nul);
    logic signed [63:0] v;
    if (nul) return;
    v = {{32{raw[31]}}, raw};
    case (model_mode)
      sqlagg_pkg::MODE_MIN:    if (!model_seen || v < model_acc) model_acc = v;
      sqlagg_pkg::MODE_MAX:    if (!model_seen || v > model_acc) model_acc = v;
      sqlagg_pkg::MODE_CHOOSE: if (!model_seen) model_acc = v;
      default:                 model_acc = model_acc + v;
    endcase
    if (model_cnt != '1) model_cnt = model_cnt + 32'd1;
    model_seen = 1'b1;
  endfunction

  // sum over count in fixed point, truncated toward zero, saturated
  function automatic logic [63:0] avg_fixed();
    logic        neg;
    logic [63:0] mag, c, q, r, frac, lim, res;
    neg = model_acc[63];
    mag = neg ? (64'd0 - model_acc) : model_acc;
    c = {32'd0, model_cnt};
    if (c == 64'd0) return 64'd0;
    q = mag / c;
    r = mag % c;
    frac = (r << FRAC) / c;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (q > (lim >> FRAC)) res = lim;
    else begin
      res = (q << FRAC) + frac;
      if (res > lim) res = lim;
    end
    return neg ? (64'd0 - res) : res;
  endfunction

  // predicted result of a finalize, then clear the state
  function automatic agg_result_t finish_group();
    agg_result_t res;
    if (!model_seen) begin
      res.value = '0;
      res.is_null = 1'b1;
    end else begin
      res.value = (model_mode == sqlagg_pkg::MODE_AVG) ? avg_fixed() : model_acc;
      res.is_null = 1'b0;
    end
    model_acc = '0;
    model_cnt = '0;
    model_seen = 1'b0;
    return res;
  endfunction

  // offer one item and record its prediction on transfer
  task automatic offer(input logic kind, input logic [sqlagg_pkg::VALUE_BITS-1:0] val,
                       input logic nul, input bit typed,
                       input logic [sqlagg_pkg::RESULT_BITS-1:0] wv, input logic wn);
    agg_result_t res;
    @(negedge clk);
    while (!quiet_tx && $urandom_range(99) < 7) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = val;
    s_tuser = {nul, kind};
    do @(posedge clk); while (!s_tready);
    if (kind == sqlagg_pkg::KIND_ADD) fold_value(val, nul);
    else begin
      res = finish_group();
      if (typed) begin
        res.value = wv;
        res.is_null = wn;
      end
      pending_results.push_back(res);
    end
  endtask

  // stop sending and wait until every result is out and the back end is quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_mode(input logic [sqlagg_pkg::MODE_BITS-1:0] m);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    model_mode = m;
  endtask

  task automatic row(input logic [sqlagg_pkg::MODE_BITS-1:0] m, input logic kind,
                     input logic [sqlagg_pkg::VALUE_BITS-1:0] val, input logic nul,
                     input bit typed, input logic [sqlagg_pkg::RESULT_BITS-1:0] wv,
                     input logic wn);
    dir_row_t d;
    d.mode = m; d.kind = kind; d.value = val; d.is_null = nul;
    d.typed = typed; d.want_value = wv; d.want_null = wn;
    dir_tab.push_back(d);
  endtask

  function automatic logic [sqlagg_pkg::VALUE_BITS-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_tready <= 1'b0;
    end else m_tready <= quiet_rx || ($urandom_range(99) >= 7);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    agg_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual value %h null %b",
                 $time, m_tdata, m_tuser);
      end else begin
        w = pending_results.pop_front();
        if (m_tdata !== w.value) begin
          errors++;
          $display("%0t result_value mismatch: expected %h, actual %h", $time, w.value, m_tdata);
        end
        if (m_tuser !== w.is_null) begin
          errors++;
          $display("%0t result_null mismatch: expected %b, actual %b", $time, w.is_null, m_tuser);
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("sql_aggregate_accumulator regression: fail");
    $finish;
  end

  // main sequence
  initial begin
    dir_row_t d;
    int n;
    logic fin;
    logic [sqlagg_pkg::MODE_BITS-1:0] phase_mode;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    model_mode = sqlagg_pkg::MODE_SUM;
    model_acc = '0;
    model_cnt = '0;
    model_seen = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: sum extremes and wrap of sign, null skipping, each mode
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1, 64'h0, 1'b1);
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_ADD, 32'h7fff_ffff, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_ADD, 32'h7fff_ffff, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1,
        64'h0000_0000_ffff_fffe, 1'b0);
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_ADD, 32'h8000_0000, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_ADD, 32'hffff_ffff, 1'b0, 0, '0, 1'b0);
    // finalize ignores its value and null flag
    row(sqlagg_pkg::MODE_SUM, sqlagg_pkg::KIND_FIN, 32'hffff_ffff, 1'b1, 1,
        64'hffff_ffff_7fff_ffff, 1'b0);
    row(sqlagg_pkg::MODE_MIN, sqlagg_pkg::KIND_ADD, 32'd5, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_MIN, sqlagg_pkg::KIND_ADD, 32'hffff_fffd, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_MIN, sqlagg_pkg::KIND_ADD, 32'h8000_0000, 1'b1, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_MIN, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1,
        64'hffff_ffff_ffff_fffd, 1'b0);
    row(sqlagg_pkg::MODE_MAX, sqlagg_pkg::KIND_ADD, 32'h8000_0000, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_MAX, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1,
        64'hffff_ffff_8000_0000, 1'b0);
    row(sqlagg_pkg::MODE_CHOOSE, sqlagg_pkg::KIND_ADD, 32'd9, 1'b1, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_CHOOSE, sqlagg_pkg::KIND_ADD, 32'h2a, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_CHOOSE, sqlagg_pkg::KIND_ADD, 32'h7fff_ffff, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_CHOOSE, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1, 64'h2a, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_ADD, 32'd1, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_ADD, 32'd2, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1, 64'h1_8000, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_ADD, 32'hffff_ffff, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_ADD, 32'hffff_fffe, 1'b0, 0, '0, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1,
        64'hffff_ffff_fffe_8000, 1'b0);
    row(sqlagg_pkg::MODE_AVG, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 1, 64'h0, 1'b1);
    // unused mode code behaves as sum
    row(MODE_SPARE, sqlagg_pkg::KIND_ADD, 32'h7fff_ffff, 1'b0, 0, '0, 1'b0);
    row(MODE_SPARE, sqlagg_pkg::KIND_FIN, 32'h0, 1'b0, 0, '0, 1'b0);

    foreach (dir_tab[i]) begin
      d = dir_tab[i];
      if (d.mode != model_mode) set_mode(d.mode);
      offer(d.kind, d.value, d.is_null, d.typed, d.want_value, d.want_null);
    end

    // back-pressure: receiver holds off while items keep coming
    set_mode(sqlagg_pkg::MODE_SUM);
    hold_token = hold_token + 1;
    quiet_tx = 1;
    for (int i = 0; i < 40; i++)
      offer((i % 3 == 2) ? sqlagg_pkg::KIND_FIN : sqlagg_pkg::KIND_ADD, rand_value(), 1'b0,
            0, '0, 1'b0);
    quiet_tx = 0;

    // random groups; a group may end without finalize so the next mode sees old state
    for (int p = 0; p < 12; p++) begin
      phase_mode = (p < 8) ? 3'(p) : 3'($urandom_range(7));
      set_mode(phase_mode);
      quiet_tx = (p == 5);
      quiet_rx = (p == 5);
      n = $urandom_range(30, 50);
      for (int i = 0; i < n; i++) begin
        fin = ($urandom_range(7) == 0);
        if (i == n - 1) fin = ($urandom_range(3) != 0);
        offer(fin ? sqlagg_pkg::KIND_FIN : sqlagg_pkg::KIND_ADD, rand_value(),
              $urandom_range(4) == 0, 0, '0, 1'b0);
      end
    end
    quiet_tx = 0;
    quiet_rx = 0;

    // flush the last group
    offer(sqlagg_pkg::KIND_FIN, rand_value(), 1'b0, 0, '0, 1'b0);
    settle();

    if (errors == 0) $display("sql_aggregate_accumulator regression: pass");
    else $display("sql_aggregate_accumulator regression: fail");
    $finish;
  end

endmodule
